// ----- hdl/mbd_pkg.sv -----
// Shared types and constants for the MBAP frame deframer.
// No dependencies; imported by every module of the block except mbd_ram.
package mbd_pkg;

  // Input kinds carried on in_tuser
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Result kinds carried on out_tuser
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DONE    = 3'd1;
  localparam logic [2:0] EV_BAD_PID = 3'd2;
  localparam logic [2:0] EV_BAD_LEN = 3'd3;
  localparam logic [2:0] EV_GAP     = 3'd4;

  // Frame phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_MBAP   = 2'd1;
  localparam logic [1:0] PH_PDU    = 2'd2;

  localparam logic [15:0] HDR_BYTES  = 16'd4;
  localparam logic [15:0] MBAP_BYTES = 16'd3;

  // Register map (word index taken from paddr[2])
  localparam logic REG_GAP_TICKS   = 1'b0;
  localparam logic REG_MAX_ADU_LEN = 1'b1;

  localparam logic [15:0] GAP_TICKS_RST   = 16'd100;
  localparam logic [9:0]  MAX_ADU_LEN_RST = 10'd260;

  // Result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       valid;
    logic       is_read;
    logic [2:0] event_res;
    logic [9:0] frame_len;
  } stage_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [9:0] frame_len;
    logic [7:0] read_data;
  } result_t;

endpackage

// ----- hdl/mbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mbd_front.sv -----
// Front end: accepts input beats, runs the MBAP phase machine, drives the buffer RAM.
// Depends on mbd_pkg; feeds a stage record to mbd_back.
module mbd_front #(
  parameter int BUF_DEPTH = 512,
  parameter int AW        = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           opcode,
  input  logic [7:0]           data_byte,
  input  logic [8:0]           read_index,
  input  logic [15:0]          gap_ticks,
  input  logic [9:0]           max_adu_len,
  input  logic [mbd_pkg::QCW-1:0] occupancy,
  output mbd_pkg::stage_t      stage,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr
);
  import mbd_pkg::*;

  logic [1:0]  phase_r,   phase_nxt;
  logic [9:0]  bcnt_r,    bcnt_nxt;
  logic [15:0] brem_r,    brem_nxt;
  logic [7:0]  len_hi_r,  len_hi_nxt;
  logic [7:0]  len_lo_r,  len_lo_nxt;
  logic [15:0] idle_r,    idle_nxt;
  logic        pid_bad_r, pid_bad_nxt;
  stage_t      stage_r,   stage_nxt;

  logic        accept;
  logic [9:0]  bcnt_inc;
  logic [15:0] brem_dec;
  logic [15:0] len;
  logic [16:0] len_sum;
  logic [16:0] max_ext;
  logic [15:0] idle_inc;
  logic        wr_ok;

  assign in_tready = (32'(occupancy) + 32'(stage_r.valid)) < QDEPTH;
  assign accept    = in_tvalid && in_tready;

  assign bcnt_inc = bcnt_r + 10'd1;
  assign brem_dec = brem_r - 16'd1;
  assign len      = {len_hi_r, len_lo_r};
  assign len_sum  = {1'b0, len} + 17'd6;
  assign max_ext  = (32'(max_adu_len) < BUF_DEPTH) ? 17'(max_adu_len) : 17'(BUF_DEPTH);
  assign idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
  assign wr_ok    = 32'(bcnt_r) < BUF_DEPTH;

  assign ram_waddr = AW'(bcnt_r);
  assign ram_wdata = data_byte;
  assign ram_raddr = AW'(read_index);

  always_comb begin
    phase_nxt   = phase_r;
    bcnt_nxt    = bcnt_r;
    brem_nxt    = brem_r;
    len_hi_nxt  = len_hi_r;
    len_lo_nxt  = len_lo_r;
    idle_nxt    = idle_r;
    pid_bad_nxt = pid_bad_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    stage_nxt.valid     = accept;
    stage_nxt.is_read   = 1'b0;
    stage_nxt.event_res = EV_NONE;
    stage_nxt.frame_len = '0;

    if (accept) begin
      unique case (opcode)
        OP_BYTE: begin
          idle_nxt = '0;
          unique case (phase_r)
            PH_HEADER: begin
              ram_we   = wr_ok;
              bcnt_nxt = bcnt_inc;
              brem_nxt = brem_dec;
              if (brem_r == 16'd2) begin
                pid_bad_nxt = (data_byte != 8'd0);
              end
              if (brem_r == 16'd1) begin
                if (pid_bad_r || (data_byte != 8'd0)) begin
                  // drop the frame on a non-zero protocol id
                  phase_nxt = PH_HEADER;
                  bcnt_nxt  = '0;
                  brem_nxt  = HDR_BYTES;
                  stage_nxt.event_res = EV_BAD_PID;
                end else begin
                  phase_nxt = PH_MBAP;
                  brem_nxt  = MBAP_BYTES;
                end
              end
            end
            PH_MBAP: begin
              ram_we   = wr_ok;
              bcnt_nxt = bcnt_inc;
              brem_nxt = brem_dec;
              if (brem_r == 16'd3) begin
                len_hi_nxt = data_byte;
              end
              if (brem_r == 16'd2) begin
                len_lo_nxt = data_byte;
              end
              if (brem_r == 16'd1) begin
                if ((len == 16'd0) || (len_sum > max_ext)) begin
                  phase_nxt = PH_HEADER;
                  bcnt_nxt  = '0;
                  brem_nxt  = HDR_BYTES;
                  stage_nxt.event_res = EV_BAD_LEN;
                end else if (len == 16'd1) begin
                  // unit id only: frame is complete now
                  phase_nxt = PH_HEADER;
                  bcnt_nxt  = '0;
                  brem_nxt  = HDR_BYTES;
                  stage_nxt.event_res = EV_DONE;
                  stage_nxt.frame_len = bcnt_inc;
                end else begin
                  phase_nxt = PH_PDU;
                  brem_nxt  = len - 16'd1;
                end
              end
            end
            PH_PDU: begin
              ram_we   = wr_ok;
              bcnt_nxt = bcnt_inc;
              brem_nxt = brem_dec;
              if (brem_r == 16'd1) begin
                phase_nxt = PH_HEADER;
                bcnt_nxt  = '0;
                brem_nxt  = HDR_BYTES;
                stage_nxt.event_res = EV_DONE;
                stage_nxt.frame_len = bcnt_inc;
              end
            end
            default: begin
              // recover from an unused phase code
              phase_nxt = PH_HEADER;
              bcnt_nxt  = '0;
              brem_nxt  = HDR_BYTES;
            end
          endcase
        end
        OP_TICK: begin
          if (idle_inc >= gap_ticks) begin
            idle_nxt = '0;
            if (bcnt_r != 10'd0) begin
              phase_nxt = PH_HEADER;
              bcnt_nxt  = '0;
              brem_nxt  = HDR_BYTES;
              stage_nxt.event_res = EV_GAP;
            end
          end else begin
            idle_nxt = idle_inc;
          end
        end
        OP_READ: begin
          ram_re            = (32'(read_index) < BUF_DEPTH);
          stage_nxt.is_read = ram_re;
        end
        OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r          <= len_lo_nxt;
    stage_r.is_read   <= stage_nxt.is_read;
    stage_r.event_res <= stage_nxt.event_res;
    stage_r.frame_len <= stage_nxt.frame_len;
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      bcnt_r        <= '0;
      brem_r        <= HDR_BYTES;
      len_hi_r      <= '0;
      idle_r        <= '0;
      pid_bad_r     <= 1'b0;
      stage_r.valid <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      bcnt_r        <= bcnt_nxt;
      brem_r        <= brem_nxt;
      len_hi_r      <= len_hi_nxt;
      idle_r        <= idle_nxt;
      pid_bad_r     <= pid_bad_nxt;
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage = stage_r;

endmodule

// ----- hdl/mbd_back.sv -----
// Back end: merges buffer read data into results and queues them for the output channel.
// Depends on mbd_pkg; takes the stage record from mbd_front.
module mbd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbd_pkg::stage_t         stage,
  input  logic [7:0]              ram_rdata,
  output logic [mbd_pkg::QCW-1:0] occupancy,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output mbd_pkg::result_t        out_res
);
  import mbd_pkg::*;

  result_t          q_mem [QDEPTH];
  logic [QAW-1:0]   head_r, head_nxt;
  logic [QAW-1:0]   tail_r, tail_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push, pop;
  result_t          entry;

  assign push = stage.valid;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    entry.event_res = stage.event_res;
    entry.frame_len = stage.frame_len;
    entry.read_data = stage.is_read ? ram_rdata : 8'd0;
    head_nxt  = pop  ? head_r + QAW'(1) : head_r;
    tail_nxt  = push ? tail_r + QAW'(1) : tail_r;
    count_nxt = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail_r] <= entry;
    end
  end

  assign occupancy  = count_r;
  assign out_tvalid = (count_r != '0);
  assign out_res    = q_mem[head_r];

endmodule

// ----- hdl/mbap_frame_deframer.sv -----
// Top level of the MBAP frame deframer: config registers, front end, buffer RAM, back end.
// Depends on mbd_pkg, mbd_ram, mbd_front and mbd_back.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------------------
//  in_       | in  | in_tvalid / in_tready   | tuser: opcode; tdata: data_byte, read_index
//  out_      | out | out_tvalid / out_tready | tuser: event_res; tdata: frame_len, read_data
//  cfg_      | in  | APB write/read          | gap_ticks @0x0, max_adu_len @0x4
//
// One beat is accepted per cycle while in_tready is high; each beat yields one result beat,
// registered in the stage record and then queued. The buffer RAM is written and read
// through a single port pair, one access per beat. A four-entry result queue parts the
// output from the front end: the input stalls once the queued results plus the beat in
// the read stage reach four.
// Reset (synchronous, active low) returns to the header phase and empties the queue;
// buffer contents are left as they are.
module mbap_frame_deframer #(
  parameter int BUF_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [16:8] read_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] frame_len, [17:10] read_data, rest zero
  output logic [2:0]  out_tuser,  // [2:0] event_res
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mbd_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic [15:0]    gap_ticks_r;
  logic [9:0]     max_adu_len_r;
  logic           cfg_wr;

  stage_t         stage;
  result_t        out_res;
  logic [QCW-1:0] occupancy;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  // Config port: no wait states, word index in paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r   <= GAP_TICKS_RST;
      max_adu_len_r <= MAX_ADU_LEN_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_GAP_TICKS) begin
        gap_ticks_r <= cfg_pwdata[15:0];
      end else begin
        max_adu_len_r <= cfg_pwdata[9:0];
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_GAP_TICKS:   cfg_prdata = {16'd0, gap_ticks_r};
      REG_MAX_ADU_LEN: cfg_prdata = {22'd0, max_adu_len_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Front end: phase machine and buffer access
  mbd_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .opcode      (in_tuser),
    .data_byte   (in_tdata[7:0]),
    .read_index  (in_tdata[16:8]),
    .gap_ticks   (gap_ticks_r),
    .max_adu_len (max_adu_len_r),
    .occupancy   (occupancy),
    .stage       (stage),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  // Frame buffer
  mbd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back end: result queue and output
  mbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .ram_rdata  (ram_rdata),
    .occupancy  (occupancy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {6'd0, out_res.read_data, out_res.frame_len};
  assign out_tuser = out_res.event_res;

endmodule

// ----- hdl/mbd_checker.sv -----
// Port-level checks for the MBAP frame deframer, bound to the top level.
// Depends on mbd_pkg.
module mbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        cfg_pready
);
  import mbd_pkg::*;

  // Queue empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Length only accompanies a completed frame
  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_DONE) |-> (out_tdata[9:0] == 10'd0))
    else $error("frame length without completed frame");

  // Events come from bytes and ticks, never from buffer reads
  a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_NONE) |-> (out_tdata[17:10] == 8'd0))
    else $error("read data alongside an event");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port inserted a wait state");

endmodule

bind mbap_frame_deframer mbd_checker u_mbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for mbap_frame_deframer: stream stimulus, APB register setup,
// and an in-order shadow deframer. Depends on mbd_pkg and the RTL of the block only.
module testbench;
  import mbd_pkg::*;

  localparam int DEPTH       = 512;
  localparam int HOLD_CYCLES = 48;      // long receiver hold-off, enough to fill the queue
  localparam int DRAIN_WAIT  = 8;       // quiet time after the last owed result, before the verdict
  localparam int LIMIT       = 400000;  // well beyond the slowest legal run
  localparam int PHASE_BEATS = 120;

  localparam result_t NO_RESULT = '0;

  // Directed plan: a beat with an optional hand-written result, or a register write
  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [7:0]  data;
    logic [8:0]  idx;
    logic        typed;
    result_t     want;
    logic        reg_sel;
    logic [15:0] reg_val;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] data_byte, [16:8] read_index, rest zero
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [9:0] frame_len, [17:10] read_data, rest zero
  logic [2:0]  out_tuser;       // [2:0] event_res
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mbap_frame_deframer #(.BUF_DEPTH(DEPTH)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Shadow deframer: register copies, frame state and buffer image
  // ---------------------------------------------------------------------------
  logic [15:0] reg_gap = GAP_TICKS_RST;
  logic [9:0]  reg_max = MAX_ADU_LEN_RST;
  logic [1:0]  cur_phase = PH_HEADER;
  logic [9:0]  cur_count = '0;
  logic [15:0] cur_left = HDR_BYTES;
  logic [7:0]  cur_len_hi = '0;
  logic [15:0] cur_idle = '0;
  logic [7:0]  shadow_buf [DEPTH];
  int          seen_bytes = 0;      // buffer entries written so far form a prefix of this size

  result_t     due_results [$];     // results owed by the block, oldest first
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          cycles = 0;
  logic        offering = 1'b0;     // sender currently holds in_tvalid high
  logic        src_calm = 1'b0;
  logic        sink_calm = 1'b0;
  logic        sink_hold = 1'b0;

  function automatic int eff_max();
    return (reg_max < DEPTH) ? int'(reg_max) : DEPTH;
  endfunction

  function automatic void restart_frame();
    cur_phase = PH_HEADER;
    cur_count = '0;
    cur_left  = HDR_BYTES;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    if (cur_count < DEPTH) begin
      shadow_buf[cur_count[8:0]] = b;
      if (int'(cur_count) >= seen_bytes) seen_bytes = int'(cur_count) + 1;
    end
    cur_count = cur_count + 10'd1;
  endfunction

  // Advance the shadow state by one input beat and return the result it owes
  function automatic result_t deframe_step(input logic [1:0] op, input logic [7:0] b,
                                           input logic [8:0] idx);
    result_t     r;
    logic [16:0] len;
    r = NO_RESULT;
    case (op)
      OP_BYTE: begin
        cur_idle = '0;
        case (cur_phase)
          PH_HEADER: begin
            store_byte(b);
            cur_left = cur_left - 16'd1;
            if (cur_left == 0) begin
              // protocol id must be zero, otherwise drop the frame
              if (shadow_buf[2] != 0 || shadow_buf[3] != 0) begin
                restart_frame();
                r.event_res = EV_BAD_PID;
              end else begin
                cur_phase = PH_MBAP;
                cur_left  = MBAP_BYTES;
              end
            end
          end
          PH_MBAP: begin
            store_byte(b);
            if (cur_left == MBAP_BYTES) cur_len_hi = b;
            cur_left = cur_left - 16'd1;
            if (cur_left == 0) begin
              len = {1'b0, cur_len_hi, shadow_buf[5]};
              if (len == 0 || int'(len) + 6 > eff_max()) begin
                restart_frame();
                r.event_res = EV_BAD_LEN;
              end else if (len == 1) begin
                r.event_res = EV_DONE;
                r.frame_len = cur_count;
                restart_frame();
              end else begin
                cur_phase = PH_PDU;
                cur_left  = len[15:0] - 16'd1;
              end
            end
          end
          PH_PDU: begin
            store_byte(b);
            cur_left = cur_left - 16'd1;
            if (cur_left == 0) begin
              r.event_res = EV_DONE;
              r.frame_len = cur_count;
              restart_frame();
            end
          end
          default: restart_frame();
        endcase
      end
      OP_TICK: begin
        if (cur_idle != 16'hFFFF) cur_idle = cur_idle + 16'd1;
        if (cur_idle >= reg_gap) begin
          cur_idle = '0;
          // only a partial frame turns the gap into an event
          if (cur_count != 0) begin
            restart_frame();
            r.event_res = EV_GAP;
          end
        end
      end
      OP_READ: r.read_data = shadow_buf[idx];
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one beat per call, random gap in front unless the side is calm
  // ---------------------------------------------------------------------------
  task automatic offer_item(input logic [1:0] op, input logic [7:0] b, input logic [8:0] idx,
                            input logic typed, input result_t want);
    int      gap_n;
    result_t pred;
    gap_n = src_calm ? 0 : $urandom_range(0, 8);
    if (gap_n != 0) begin
      if (offering) in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap_n) @(posedge clk);
    end
    pred = deframe_step(op, b, idx);
    due_results.push_back(typed ? want : pred);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, idx, b};
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic settle();
    if (offering) in_tvalid <= 1'b0;
    offering = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Write a register, read it back, and mirror it into the shadow copy
  task automatic apb_write(input logic sel, input logic [15:0] val);
    logic [31:0] want;
    want = (sel == REG_GAP_TICKS) ? {16'd0, val} : {22'd0, val[9:0]};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want)
      note_fail($sformatf("reg %0d read back %h, wrote %h", sel, cfg_prdata, want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (sel == REG_GAP_TICKS) reg_gap = val;
    else reg_max = val[9:0];
  endtask

  // Reads only reach entries written since reset
  task automatic offer_noise(input logic mid_frame);
    logic [1:0] op;
    logic [8:0] idx;
    int         pick;
    pick = $urandom_range(0, 9);
    if (mid_frame) op = (pick < 4) ? OP_READ : (pick < 8) ? OP_NOP : OP_TICK;
    else op = 2'($urandom_range(0, 3));
    idx = 9'($urandom_range(0, DEPTH - 1));
    if (op == OP_READ) begin
      if (seen_bytes == 0) op = OP_NOP;
      else idx = 9'($urandom_range(0, seen_bytes - 1));
    end
    offer_item(op, 8'($urandom_range(0, 255)), idx, 1'b0, NO_RESULT);
  endtask

  // Send the first n_bytes of an ADU carrying length word len_w
  task automatic offer_frame(input logic [15:0] len_w, input int n_bytes, input logic bad_pid);
    logic [7:0] b;
    int         k;
    for (k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 99) < 8) offer_noise(1'b1);
      case (k)
        2:       b = bad_pid ? 8'($urandom_range(0, 255)) : 8'h00;
        3:       b = bad_pid ? 8'($urandom_range(1, 255)) : 8'h00;
        4:       b = len_w[15:8];
        5:       b = len_w[7:0];
        default: b = 8'($urandom_range(0, 255));
      endcase
      offer_item(OP_BYTE, b, 9'($urandom_range(0, DEPTH - 1)), 1'b0, NO_RESULT);
    end
  endtask

  function automatic logic [15:0] pick_good_len(input int eff);
    int top;
    top = eff - 6;
    if (top < 1) return 16'($urandom_range(1, 8));
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(1, top));
    return 16'($urandom_range(1, (top < 12) ? top : 12));
  endfunction

  // One register setting, then mostly well-formed frames with random content
  task automatic run_phase(input logic [15:0] gap, input logic [15:0] max_len,
                           input logic calm, input logic hold, input logic big_frame);
    int          start;
    int          kind;
    int          eff;
    int          k;
    logic [15:0] len_w;
    settle();
    apb_write(REG_GAP_TICKS, gap);
    apb_write(REG_MAX_ADU_LEN, max_len);
    src_calm  = calm;
    sink_calm = calm;
    if (hold) sink_hold = 1'b1;
    eff   = eff_max();
    start = beats_sent;
    // largest frame the buffer takes, so every read_index bit toggles
    if (big_frame) offer_frame(16'(DEPTH - 6), DEPTH, 1'b0);
    while (beats_sent - start < PHASE_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        len_w = pick_good_len(eff);
        offer_frame(len_w, (eff < 7) ? 7 : int'(len_w) + 6, 1'b0);
      end else if (kind < 73) begin
        offer_frame(16'($urandom_range(0, 65535)), 4, 1'b1);
      end else if (kind < 81) begin
        // length zero, just over the limit, or anywhere above it
        k = $urandom_range(0, 3);
        if (k == 0) len_w = '0;
        else if (k == 1) len_w = (eff > 5) ? 16'(eff - 5) : 16'd1;
        else len_w = 16'($urandom_range((eff > 5) ? eff - 5 : 1, 65535));
        offer_frame(len_w, 7, 1'b0);
      end else if (kind < 90) begin
        // cut the frame short, then idle so a small gap limit drops it
        len_w = pick_good_len(eff);
        offer_frame(len_w, $urandom_range(1, int'(len_w) + 5), 1'b0);
        repeat ($urandom_range(1, 12))
          offer_item(OP_TICK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, DEPTH - 1)),
                     1'b0, NO_RESULT);
      end else begin
        repeat ($urandom_range(1, 6)) offer_noise(1'b0);
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic plan_beat(input logic [1:0] op, input logic [7:0] b, input logic [8:0] idx,
                           input logic typed, input logic [2:0] ev, input logic [9:0] flen,
                           input logic [7:0] rd);
    plan_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.op = op;
    row.data = b;
    row.idx = idx;
    row.typed = typed;
    row.want.event_res = ev;
    row.want.frame_len = flen;
    row.want.read_data = rd;
    plan.push_back(row);
  endtask

  task automatic plan_reg(input logic sel, input logic [15:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_sel = sel;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall per beat, plus one long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_n = sink_calm ? 0 : $urandom_range(0, 8);
        if (wait_n != 0) begin
          out_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Compare every accepted result beat with the oldest owed result
  result_t owed;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        note_fail($sformatf("unexpected beat ev=%0d len=%0d rd=%h",
                            out_tuser, out_tdata[9:0], out_tdata[17:10]));
      end else begin
        owed = due_results.pop_front();
        if (out_tuser !== owed.event_res || out_tdata[9:0] !== owed.frame_len ||
            out_tdata[17:10] !== owed.read_data)
          note_fail($sformatf("want ev=%0d len=%0d rd=%h, got ev=%0d len=%0d rd=%h",
                              owed.event_res, owed.frame_len, owed.read_data,
                              out_tuser, out_tdata[9:0], out_tdata[17:10]));
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL mbap_frame_deframer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: directed plan, then randomised phases across register settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // no-op ignores every field
    plan_beat(OP_NOP, 8'hFF, 9'h1FF, 1'b1, EV_NONE, 10'd0, 8'h00);
    // length one: seven bytes complete the frame at once
    plan_beat(OP_BYTE, 8'hFF, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h01, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'hFF, 9'd0, 1'b1, EV_DONE, 10'd7, 8'h00);
    plan_beat(OP_READ, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'hFF);
    // non-zero protocol id: reject on the fourth byte
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'hFF, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h01, 9'd0, 1'b1, EV_BAD_PID, 10'd0, 8'h00);
    // length zero: rejected once the MBAP header is in
    for (k = 0; k < 6; k++) plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'hFF, 9'd0, 1'b1, EV_BAD_LEN, 10'd0, 8'h00);
    // gap limit of zero: every tick reaches it, event only with a partial frame
    plan_reg(REG_GAP_TICKS, 16'd0);
    plan_beat(OP_TICK, 8'h00, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'hA5, 9'd0, 1'b1, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_TICK, 8'h00, 9'd0, 1'b1, EV_GAP, 10'd0, 8'h00);
    // maximum below seven: even a length-one frame is rejected
    plan_reg(REG_MAX_ADU_LEN, 16'd6);
    for (k = 0; k < 5; k++) plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b0, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h01, 9'd0, 1'b0, EV_NONE, 10'd0, 8'h00);
    plan_beat(OP_BYTE, 8'h00, 9'd0, 1'b1, EV_BAD_LEN, 10'd0, 8'h00);
    plan_beat(OP_READ, 8'h00, 9'd5, 1'b0, EV_NONE, 10'd0, 8'h00);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_REG) begin
        settle();
        apb_write(plan[k].reg_sel, plan[k].reg_val);
      end else begin
        offer_item(plan[k].op, plan[k].data, plan[k].idx, plan[k].typed, plan[k].want);
      end
    end

    //        gap     max     calm  hold  big
    run_phase(16'd3,     16'd8,    1'b0, 1'b1, 1'b0);
    run_phase(16'd65535, 16'd512,  1'b1, 1'b0, 1'b1);
    run_phase(16'd1,     16'd1023, 1'b0, 1'b0, 1'b0);
    run_phase(16'd0,     16'd260,  1'b0, 1'b0, 1'b0);
    run_phase(16'd5,     16'd6,    1'b0, 1'b0, 1'b0);
    run_phase(16'd12,    16'd100,  1'b0, 1'b1, 1'b0);
    run_phase(16'd100,   16'd260,  1'b0, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) $display("PASS mbap_frame_deframer");
    else $display("FAIL mbap_frame_deframer");
    $finish;
  end

endmodule
